/* design/irs_pkg.sv */
// ---------------------------------------------------------------------------
// irs_pkg: shared types for the interval row edge sweep
// Coordinate, boundary, word, command and status types, plus the boundary order.
// ---------------------------------------------------------------------------
`default_nettype none

package irs_pkg;

    localparam int MaxRects  = 32;
    localparam int MaxBounds = 2 * MaxRects;
    localparam int CountBits = $clog2(MaxBounds + 1);
    localparam int CoordBits = 32;
    localparam int OvBits    = 8;

    typedef logic signed [CoordBits-1:0] coord_t;
    typedef logic [CountBits-1:0]        count_t;
    typedef logic signed [OvBits-1:0]    overlap_t;

    typedef struct packed {
        coord_t x;
        logic   is_end;
    } bound_t;

    typedef struct packed {
        coord_t x_low;
        coord_t x_high;
        coord_t line_y;
        logic   last_rect;
    } in_item_t;

    typedef struct packed {
        coord_t seg_x_start;
        coord_t seg_x_end;
        coord_t seg_y;
        logic   last_segment;
        logic   none_found;
        logic   store_overflow;
    } out_item_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic ins_start;   // insert x_low of the input word as a start
        logic ins_end;     // insert the held x_high as an end
        logic capture;     // hold x_high and line_y of the input word
        logic set_ovf;     // the input word was dropped
        logic step;        // sweep one boundary
        logic flush;       // deliver the final word of the line
    } cmd_t;

    typedef struct packed {
        logic list_empty;
        logic room;
        logic need_out;
        logic out_free;
    } stat_t;

    // True if a sorts strictly ahead of b: by x, then starts ahead of ends.
    function automatic logic sorts_ahead(bound_t a, bound_t b);
        logic lt;
        logic eq;
        lt = $signed(a.x) < $signed(b.x);
        eq = a.x == b.x;
        return lt || (eq && !a.is_end && b.is_end);
    endfunction

endpackage

`default_nettype wire

/* design/irs_sorter.sv */
// ---------------------------------------------------------------------------
// irs_sorter: insertion sorter over a row of boundary cells
// Each cell compares against the new boundary; one insert or pop per cycle.
// ---------------------------------------------------------------------------
`default_nettype none

module irs_sorter (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            ins_valid,
    input  wire irs_pkg::bound_t ins_bound,
    input  wire logic            pop,
    output irs_pkg::bound_t      head,
    output irs_pkg::count_t      count
);

    irs_pkg::bound_t cell_reg [irs_pkg::MaxBounds];
    irs_pkg::bound_t cell_next[irs_pkg::MaxBounds];
    irs_pkg::count_t count_reg;
    irs_pkg::count_t count_next;
    logic [irs_pkg::MaxBounds-1:0] lt;

    always_comb
    begin
        for (int i = 0; i < irs_pkg::MaxBounds; i++)
        begin
            lt[i] = (irs_pkg::count_t'(i) < count_reg)
                    && irs_pkg::sorts_ahead(cell_reg[i], ins_bound);
        end
    end

    always_comb
    begin
        count_next = count_reg;
        for (int i = 0; i < irs_pkg::MaxBounds; i++)
        begin
            cell_next[i] = cell_reg[i];
        end
        if (ins_valid)
        begin
            count_next = count_reg + irs_pkg::count_t'(1);
            if (!lt[0])
                cell_next[0] = ins_bound;
            for (int i = 1; i < irs_pkg::MaxBounds; i++)
            begin
                if (lt[i])
                    cell_next[i] = cell_reg[i];
                else if (lt[i-1])
                    cell_next[i] = ins_bound;
                else
                    cell_next[i] = cell_reg[i-1];
            end
        end
        else if (pop)
        begin
            count_next = count_reg - irs_pkg::count_t'(1);
            for (int i = 0; i < irs_pkg::MaxBounds - 1; i++)
            begin
                cell_next[i] = cell_reg[i+1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else
            count_reg <= count_next;
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < irs_pkg::MaxBounds; i++)
        begin
            cell_reg[i] <= cell_next[i];
        end
    end

    assign head  = cell_reg[0];
    assign count = count_reg;

endmodule

`default_nettype wire

/* design/irs_datapath.sv */
// ---------------------------------------------------------------------------
// irs_datapath: boundary store, overlap sweep and output register
// Holds one pending segment so that the last word of a line can be marked.
// ---------------------------------------------------------------------------
`default_nettype none

module irs_datapath (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire irs_pkg::cmd_t     cmd,
    output irs_pkg::stat_t         stat,
    input  wire irs_pkg::in_item_t in_data,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output irs_pkg::out_item_t     out_data
);

    irs_pkg::coord_t    x_high_reg;
    irs_pkg::coord_t    y_reg;
    irs_pkg::overlap_t  ov_reg;
    irs_pkg::overlap_t  ov_next;
    irs_pkg::coord_t    open_reg;
    irs_pkg::coord_t    pend_xs_reg;
    irs_pkg::coord_t    pend_xe_reg;
    logic               pend_valid_reg;
    logic               ovf_reg;
    logic               out_valid_reg;
    irs_pkg::out_item_t out_reg;

    irs_pkg::bound_t ins_bound;
    irs_pkg::bound_t head;
    irs_pkg::count_t count;
    logic            emit;
    logic            open_now;
    logic            out_free;
    logic            load_out;

    always_comb
    begin
        if (cmd.ins_start)
            ins_bound = '{x: in_data.x_low, is_end: 1'b0};
        else
            ins_bound = '{x: x_high_reg, is_end: 1'b1};
    end

    irs_sorter u_sorter (
        .clk       (clk),
        .rst_n     (rst_n),
        .ins_valid (cmd.ins_start | cmd.ins_end),
        .ins_bound (ins_bound),
        .pop       (cmd.step),
        .head      (head),
        .count     (count)
    );

    always_comb
    begin
        if (head.is_end)
        begin
            ov_next = ov_reg - irs_pkg::overlap_t'(1);
            emit    = ov_next == irs_pkg::overlap_t'(0);
        end
        else
        begin
            ov_next = ov_reg + irs_pkg::overlap_t'(1);
            emit    = ov_next == irs_pkg::overlap_t'(2);
        end
        open_now = ov_next == irs_pkg::overlap_t'(1);
    end

    assign out_free = !out_valid_reg || out_ready;
    assign load_out = (cmd.step && emit && pend_valid_reg) || cmd.flush;

    assign stat.list_empty = count == '0;
    assign stat.room       = count <= irs_pkg::count_t'(irs_pkg::MaxBounds - 2);
    assign stat.need_out   = emit && pend_valid_reg;
    assign stat.out_free   = out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ov_reg         <= '0;
            open_reg       <= '0;
            pend_valid_reg <= 1'b0;
            ovf_reg        <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;
            if (load_out)
                out_valid_reg <= 1'b1;
            if (cmd.set_ovf)
                ovf_reg <= 1'b1;
            if (cmd.step)
            begin
                ov_reg <= ov_next;
                if (open_now)
                    open_reg <= head.x;
                if (emit)
                    pend_valid_reg <= 1'b1;
            end
            if (cmd.flush)
            begin
                ov_reg         <= '0;
                open_reg       <= '0;
                pend_valid_reg <= 1'b0;
                ovf_reg        <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            x_high_reg <= in_data.x_high;
            y_reg      <= in_data.line_y;
        end
        if (cmd.step && emit)
        begin
            pend_xs_reg <= open_reg;
            pend_xe_reg <= head.x;
        end
        if (cmd.step && emit && pend_valid_reg)
        begin
            out_reg <= '{seg_x_start: pend_xs_reg, seg_x_end: pend_xe_reg,
                         seg_y: y_reg, last_segment: 1'b0, none_found: 1'b0,
                         store_overflow: ovf_reg};
        end
        else if (cmd.flush)
        begin
            if (pend_valid_reg)
                out_reg <= '{seg_x_start: pend_xs_reg, seg_x_end: pend_xe_reg,
                             seg_y: y_reg, last_segment: 1'b1, none_found: 1'b0,
                             store_overflow: ovf_reg};
            else
                out_reg <= '{seg_x_start: '0, seg_x_end: '0, seg_y: '0,
                             last_segment: 1'b1, none_found: 1'b1,
                             store_overflow: ovf_reg};
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // A word is never written over one that has not been taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        load_out |-> out_free)
        else $error("output word overwritten");

    // The store never holds more boundaries than it has cells.
    assert property (@(posedge clk) disable iff (!rst_n)
        count <= irs_pkg::count_t'(irs_pkg::MaxBounds))
        else $error("boundary store overfilled");

    // Finishing a line leaves no pending segment behind.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.flush |=> !pend_valid_reg)
        else $error("pending segment survived line end");

endmodule

`default_nettype wire

/* design/irs_ctrl.sv */
// ---------------------------------------------------------------------------
// irs_ctrl: controller for the interval row edge sweep
// Sequences insertion of both boundaries, the sweep and the final word.
// ---------------------------------------------------------------------------
`default_nettype none

module irs_ctrl (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_ready,
    input  wire logic           in_last,
    input  wire irs_pkg::stat_t stat,
    output irs_pkg::cmd_t       cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_END,
        S_SWEEP,
        S_FLUSH
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   last_reg;
    logic   last_next;

    always_comb
    begin
        state_next = state_reg;
        last_next  = last_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    last_next   = in_last;
                    if (stat.room)
                    begin
                        cmd.ins_start = 1'b1;
                        state_next    = S_END;
                    end
                    else
                    begin
                        cmd.set_ovf = 1'b1;
                        state_next  = in_last ? S_SWEEP : S_IDLE;
                    end
                end
            end
            S_END:
            begin
                cmd.ins_end = 1'b1;
                state_next  = last_reg ? S_SWEEP : S_IDLE;
            end
            S_SWEEP:
            begin
                if (stat.list_empty)
                    state_next = S_FLUSH;
                else if (!stat.need_out || stat.out_free)
                    cmd.step = 1'b1;
            end
            S_FLUSH:
            begin
                if (stat.out_free)
                begin
                    cmd.flush  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            last_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            last_reg  <= last_next;
        end
    end

endmodule

`default_nettype wire

/* design/interval_row_edge_sweep_unit.sv */
// ---------------------------------------------------------------------------
// interval_row_edge_sweep_unit: singly covered spans of one horizontal line
// Sorts rectangle x boundaries, sweeps them and emits spans of coverage one.
// ---------------------------------------------------------------------------
// Each input word puts its start and end boundaries one per cycle into a row
// of compare-and-shift cells that keeps them sorted; the next word is taken
// once the end boundary is in. A word that arrives once 32 rectangles are held
// is dropped. After the word marked last, the sweep pops one boundary per cycle
// from the head of the row, then sees the row empty and loads the final word,
// stalling while a segment or the final word waits on an untaken output word.
// The next line is accepted in the cycle after the final word is loaded into
// the output register.
`default_nettype none

module interval_row_edge_sweep_unit (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire irs_pkg::in_item_t in_data,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output irs_pkg::out_item_t     out_data
);

    irs_pkg::cmd_t  cmd;
    irs_pkg::stat_t stat;

    irs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_last  (in_data.last_rect),
        .stat     (stat),
        .cmd      (cmd)
    );

    irs_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

`default_nettype wire

/* bench/tb_interval_row_edge_sweep_unit.sv */
// ---------------------------------------------------------------------------
// tb_interval_row_edge_sweep_unit: self-checking bench for the edge sweep
// Sends lines of rectangles, predicts the singly covered spans of each line
// and checks every output word against the prediction in order.
// ---------------------------------------------------------------------------
`default_nettype none

class span_scoreboard;
    irs_pkg::bound_t   row[$];
    logic              ovf;
    irs_pkg::out_item_t spans_due[$];
    int                errors;
    int                lines;
    int                words_seen;

    function new();
        ovf = 1'b0;
        errors = 0;
        lines = 0;
        words_seen = 0;
    endfunction

    function void add_due(irs_pkg::out_item_t r);
        spans_due = {spans_due, r};
    endfunction

    function void insert_bound(irs_pkg::coord_t x, logic is_end);
        int pos;
        irs_pkg::bound_t b;
        b.x = x;
        b.is_end = is_end;
        pos = 0;
        while (pos < row.size() && ((row[pos].x < x) ||
               (row[pos].x == x && !row[pos].is_end && is_end)))
            pos++;
        row.insert(pos, b);
    endfunction

    function void note_rect(irs_pkg::in_item_t w);
        int ov;
        irs_pkg::coord_t open_x;
        irs_pkg::out_item_t r;
        int n;
        if (row.size() + 2 <= irs_pkg::MaxBounds) begin
            insert_bound(w.x_low, 1'b0);
            insert_bound(w.x_high, 1'b1);
        end else begin
            ovf = 1'b1;
        end
        if (!w.last_rect)
            return;
        lines++;
        ov = 0;
        open_x = '0;
        n = 0;
        foreach (row[i]) begin
            logic emit;
            emit = 1'b0;
            if (!row[i].is_end) begin
                ov++;
                if (ov == 1) open_x = row[i].x;
                else if (ov == 2) emit = 1'b1;
            end else begin
                ov--;
                if (ov == 0) emit = 1'b1;
                else if (ov == 1) open_x = row[i].x;
            end
            if (emit && n < 64) begin
                r = '0;
                r.seg_x_start = open_x;
                r.seg_x_end = row[i].x;
                r.seg_y = w.line_y;
                r.store_overflow = ovf;
                add_due(r);
                n++;
            end
        end
        if (n == 0) begin
            r = '0;
            r.none_found = 1'b1;
            r.store_overflow = ovf;
            add_due(r);
        end
        spans_due[spans_due.size()-1].last_segment = 1'b1;
        row.delete();
        ovf = 1'b0;
    endfunction

    function void check_span(irs_pkg::out_item_t got);
        irs_pkg::out_item_t e;
        words_seen++;
        if (spans_due.size() == 0) begin
            $error("unexpected output word %h", got);
            errors++;
            return;
        end
        e = spans_due.pop_front();
        if (got.seg_x_start !== e.seg_x_start) begin
            $error("seg_x_start expected %h got %h", e.seg_x_start, got.seg_x_start);
            errors++;
        end
        if (got.seg_x_end !== e.seg_x_end) begin
            $error("seg_x_end expected %h got %h", e.seg_x_end, got.seg_x_end);
            errors++;
        end
        if (got.seg_y !== e.seg_y) begin
            $error("seg_y expected %h got %h", e.seg_y, got.seg_y);
            errors++;
        end
        if (got.last_segment !== e.last_segment) begin
            $error("last_segment expected %b got %b", e.last_segment, got.last_segment);
            errors++;
        end
        if (got.none_found !== e.none_found) begin
            $error("none_found expected %b got %b", e.none_found, got.none_found);
            errors++;
        end
        if (got.store_overflow !== e.store_overflow) begin
            $error("store_overflow expected %b got %b", e.store_overflow,
                   got.store_overflow);
            errors++;
        end
    endfunction
endclass

module tb_interval_row_edge_sweep_unit;
    localparam int StallLimit = 20000;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    irs_pkg::in_item_t  in_data;
    logic               out_valid;
    logic               out_ready;
    irs_pkg::out_item_t out_data;

    span_scoreboard sb;
    bit  calm;
    bit  stim_done;
    int  idle_cycles;
    int  items_sent;

    interval_row_edge_sweep_unit i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .in_data(in_data),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_data(out_data)
    );

    initial clk = 1'b0;
    always #6 clk = ~clk;

    // Valid stays high between back-to-back words; it is lowered only for a
    // gap or when the sender pauses.
    task automatic send_rect(irs_pkg::coord_t lo, irs_pkg::coord_t hi,
                             irs_pkg::coord_t y, logic last);
        int gap;
        if (!calm && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 6);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_data <= '{x_low: lo, x_high: hi, line_y: y, last_rect: last};
        in_valid <= 1'b1;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        sb.note_rect('{x_low: lo, x_high: hi, line_y: y, last_rect: last});
        items_sent++;
    endtask

    function automatic irs_pkg::coord_t rand_coord(int spread);
        case ($urandom_range(0, 5))
            0: return irs_pkg::coord_t'($urandom);
            1: return 32'sh8000_0000 + $urandom_range(0, 3);
            2: return 32'sh7fff_ffff - $urandom_range(0, 3);
            default: return irs_pkg::coord_t'($urandom_range(0, spread)) <<< 14;
        endcase
    endfunction

    // One line of n rectangles, mostly well formed with some inverted ones.
    task automatic send_line(int n, int spread);
        irs_pkg::coord_t y;
        irs_pkg::coord_t a;
        irs_pkg::coord_t b;
        y = irs_pkg::coord_t'($urandom);
        for (int k = 0; k < n; k++) begin
            a = rand_coord(spread);
            b = rand_coord(spread);
            if ($urandom_range(0, 7) != 0 && b < a) begin
                irs_pkg::coord_t t;
                t = a;
                a = b;
                b = t;
            end
            send_rect(a, b, y, k == n - 1);
        end
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (sb.spans_due.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    always @(posedge clk) begin
        if (rst_n) begin
            if (out_valid && out_ready)
                sb.check_span(out_data);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= StallLimit) begin
                $display("watchdog: no handshake for %0d cycles", StallLimit);
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    // Output back-pressure in random bursts.
    initial begin
        out_ready = 1'b0;
        @(posedge rst_n);
        forever begin
            @(posedge clk);
            if (!calm && $urandom_range(0, 3) == 0) begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 6) - 1) @(posedge clk);
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    initial begin
        sb = new();
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        calm = 1'b0;
        stim_done = 1'b0;
        idle_cycles = 0;
        items_sent = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: single rectangle, extremes, touching, nested, inverted.
        send_rect(32'sh8000_0000, 32'sh7fff_ffff, 32'sh7fff_ffff, 1'b1);
        send_rect(32'sh0001_0000, 32'sh0001_0000, 32'sh8000_0000, 1'b1);
        send_rect(32'sh0000_0000, 32'sh0002_0000, 32'sh0000_0005, 1'b0);
        send_rect(32'sh0002_0000, 32'sh0004_0000, 32'sh0000_0005, 1'b1);
        send_rect(32'sh0000_0000, 32'sh0010_0000, -32'sh0003_0000, 1'b0);
        send_rect(32'sh0004_0000, 32'sh0008_0000, -32'sh0003_0000, 1'b1);
        send_rect(32'sh0000_0000, 32'sh0004_0000, 32'sh1, 1'b0);
        send_rect(32'sh0000_0000, 32'sh0004_0000, 32'sh1, 1'b1);
        send_rect(32'sh0005_0000, 32'sh0001_0000, 32'sh2, 1'b1);
        send_rect(32'sh0003_0000, -32'sh0003_0000, 32'sh2, 1'b0);
        send_rect(-32'sh0001_0000, 32'sh0001_0000, 32'sh2, 1'b1);
        // Pause the sender until the output side has drained.
        wait_drained();
        // Overflow: more rectangles than the store holds, last three dropped.
        send_line(irs_pkg::MaxRects + 3, 64);

        while (items_sent < 300) begin
            if ($urandom_range(0, 9) == 0)
                send_line($urandom_range(irs_pkg::MaxRects - 2,
                                         irs_pkg::MaxRects + 2), 256);
            else
                send_line($urandom_range(1, 6), 32);
        end
        wait_drained();
        calm = 1'b1;
        while (items_sent < 340)
            send_line($urandom_range(1, 5), 32);

        wait_drained();
        repeat (150) @(posedge clk);
        $display("covered %0d rectangles over %0d lines, %0d output words checked",
                 items_sent, sb.lines, sb.words_seen);
        if (sb.errors == 0 && sb.spans_due.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule

`default_nettype wire
